// File: hw/rtl/mono_last_note_priority_stack_assert.svh
// Assertion macros shared by the note stack RTL.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef MONO_LAST_NOTE_PRIORITY_STACK_ASSERT_SVH
`define MONO_LAST_NOTE_PRIORITY_STACK_ASSERT_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mlnps_pkg.sv
// Package for the mono last-note-priority note stack.
// Widths, request codes and controller/datapath interface structs; no dependencies.
package mlnps_pkg;

  localparam int STACK_DEPTH = 16;

  localparam int REQ_W  = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int HELD_W = 5;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // count must hold STACK_DEPTH itself, and at least the width of the held port
  localparam int CNT_W  = ($clog2(STACK_DEPTH + 1) > HELD_W) ?
                          $clog2(STACK_DEPTH + 1) : HELD_W;

  localparam logic [NOTE_W-1:0] RESET_NOTE = NOTE_W'(33);  // 55 Hz

  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALL_OFF  = 2'd2;

  typedef struct packed {
    logic load;       // capture request, clear scan pointers
    logic scan;       // one compaction step
    logic scan_end;   // commit compacted count, set up eviction pass
    logic shift;      // one eviction shift step
    logic shift_end;  // commit evicted count
    logic finish;     // apply request, load result register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_req;   // request needs the compaction pass
    logic note_on;
    logic scan_done;
    logic shift_done;
    logic full;
    logic out_busy;   // result register holds a beat not yet taken
  } dp_status_t;

endpackage

// File: hw/rtl/mlnps_dp.sv
// Datapath of the note stack: stack storage, scan pointers, current voice state, result register.
// Depends on mlnps_pkg and mono_last_note_priority_stack_assert.svh.
`include "mono_last_note_priority_stack_assert.svh"

module mlnps_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mlnps_pkg::dp_cmd_t            cmd,
  output mlnps_pkg::dp_status_t         status,
  input  logic [mlnps_pkg::REQ_W-1:0]   req_type,
  input  logic [mlnps_pkg::NOTE_W-1:0]  note_number,
  input  logic [mlnps_pkg::VEL_W-1:0]   note_velocity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          gate_on,
  output logic [mlnps_pkg::NOTE_W-1:0]  target_note,
  output logic [mlnps_pkg::VEL_W-1:0]   target_velocity,
  output logic [mlnps_pkg::HELD_W-1:0]  held_count,
  output logic                          oldest_dropped
);

  logic [mlnps_pkg::NOTE_W-1:0] notes [mlnps_pkg::STACK_DEPTH];
  logic [mlnps_pkg::VEL_W-1:0]  vels  [mlnps_pkg::STACK_DEPTH];

  logic [mlnps_pkg::CNT_W-1:0]  count;
  logic [mlnps_pkg::CNT_W-1:0]  rd;
  logic [mlnps_pkg::CNT_W-1:0]  wr;
  logic [mlnps_pkg::REQ_W-1:0]  req_r;
  logic [mlnps_pkg::NOTE_W-1:0] note_r;
  logic [mlnps_pkg::VEL_W-1:0]  vel_r;
  logic                         dropped;

  logic [mlnps_pkg::NOTE_W-1:0] cur_note;
  logic [mlnps_pkg::VEL_W-1:0]  cur_vel;
  logic                         gate;
  logic [mlnps_pkg::CNT_W-1:0]  out_count;

  logic [mlnps_pkg::CNT_W-1:0]  count_m1;
  logic [mlnps_pkg::ADDR_W-1:0] raddr;
  logic [mlnps_pkg::NOTE_W-1:0] rd_note;
  logic [mlnps_pkg::VEL_W-1:0]  rd_vel;
  logic                         keep;

  logic [mlnps_pkg::NOTE_W-1:0] cur_note_next;
  logic [mlnps_pkg::VEL_W-1:0]  cur_vel_next;
  logic                         gate_next;
  logic [mlnps_pkg::CNT_W-1:0]  count_next;

  // single read port: scan pointer while compacting or evicting, top of stack on finish
  assign count_m1 = count - mlnps_pkg::CNT_W'(1);
  assign raddr    = cmd.finish ? count_m1[mlnps_pkg::ADDR_W-1:0] : rd[mlnps_pkg::ADDR_W-1:0];
  assign rd_note  = notes[raddr];
  assign rd_vel   = vels[raddr];
  assign keep     = (rd_note != note_r);

  assign status.scan_req   = (req_r == mlnps_pkg::REQ_NOTE_ON) ||
                             (req_r == mlnps_pkg::REQ_NOTE_OFF);
  assign status.note_on    = (req_r == mlnps_pkg::REQ_NOTE_ON);
  assign status.scan_done  = (rd == count);
  assign status.shift_done = (rd == mlnps_pkg::CNT_W'(mlnps_pkg::STACK_DEPTH));
  assign status.full       = (count == mlnps_pkg::CNT_W'(mlnps_pkg::STACK_DEPTH));
  assign status.out_busy   = out_valid && !out_ready;

  always_comb begin
    cur_note_next = cur_note;
    cur_vel_next  = cur_vel;
    gate_next     = gate;
    count_next    = count;
    case (req_r)
      mlnps_pkg::REQ_NOTE_ON: begin
        cur_note_next = note_r;
        cur_vel_next  = vel_r;
        gate_next     = 1'b1;
        count_next    = count + mlnps_pkg::CNT_W'(1);
      end
      mlnps_pkg::REQ_NOTE_OFF: begin
        if (count == '0) begin
          gate_next = 1'b0;
        end else begin
          cur_note_next = rd_note;
          cur_vel_next  = rd_vel;
          gate_next     = 1'b1;
        end
      end
      mlnps_pkg::REQ_ALL_OFF: begin
        cur_note_next = mlnps_pkg::RESET_NOTE;
        cur_vel_next  = '0;
        gate_next     = 1'b0;
        count_next    = '0;
      end
      default: begin
      end
    endcase
  end

  // stack storage, no reset: entries at or above count are never read
  always_ff @(posedge clk) begin
    if (cmd.scan && keep) begin
      notes[wr[mlnps_pkg::ADDR_W-1:0]] <= rd_note;
      vels[wr[mlnps_pkg::ADDR_W-1:0]]  <= rd_vel;
    end else if (cmd.shift) begin
      notes[wr[mlnps_pkg::ADDR_W-1:0]] <= rd_note;
      vels[wr[mlnps_pkg::ADDR_W-1:0]]  <= rd_vel;
    end else if (cmd.finish && status.note_on) begin
      notes[count[mlnps_pkg::ADDR_W-1:0]] <= note_r;
      vels[count[mlnps_pkg::ADDR_W-1:0]]  <= vel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      note_r  <= note_number;
      vel_r   <= note_velocity;
      rd      <= '0;
      wr      <= '0;
      dropped <= 1'b0;
    end else if (cmd.scan) begin
      rd <= rd + mlnps_pkg::CNT_W'(1);
      if (keep) begin
        wr <= wr + mlnps_pkg::CNT_W'(1);
      end
    end else if (cmd.scan_end) begin
      // eviction pass copies entries 1..DEPTH-1 down to 0..DEPTH-2
      rd <= mlnps_pkg::CNT_W'(1);
      wr <= '0;
    end else if (cmd.shift) begin
      rd <= rd + mlnps_pkg::CNT_W'(1);
      wr <= wr + mlnps_pkg::CNT_W'(1);
    end else if (cmd.shift_end) begin
      dropped <= 1'b1;
    end
    if (cmd.finish) begin
      target_note     <= cur_note_next;
      target_velocity <= cur_vel_next;
      gate_on         <= gate_next;
      out_count       <= count_next;
      oldest_dropped  <= dropped && status.note_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_note  <= mlnps_pkg::RESET_NOTE;
      cur_vel   <= '0;
      gate      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_end) begin
        count <= wr;
      end else if (cmd.shift_end) begin
        count <= mlnps_pkg::CNT_W'(mlnps_pkg::STACK_DEPTH - 1);
      end else if (cmd.finish) begin
        count    <= count_next;
        cur_note <= cur_note_next;
        cur_vel  <= cur_vel_next;
        gate     <= gate_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign held_count = out_count[mlnps_pkg::HELD_W-1:0];

  `ASSERT_ALWAYS(a_count_bound, count <= mlnps_pkg::CNT_W'(mlnps_pkg::STACK_DEPTH), "stack count beyond depth")
  `ASSERT_IMPLY(a_push_room, cmd.finish && status.note_on, !status.full, "push onto a full stack")
  `ASSERT_IMPLY(a_gate_count, out_valid, gate_on == (out_count != '0), "gate disagrees with held count")
  `ASSERT_IMPLY(a_drop_full, out_valid && oldest_dropped, out_count == mlnps_pkg::CNT_W'(mlnps_pkg::STACK_DEPTH), "eviction without full stack")

endmodule

// File: hw/rtl/mlnps_ctrl.sv
// Controller of the note stack: sequences load, compaction, eviction and result.
// Depends on mlnps_pkg and mono_last_note_priority_stack_assert.svh.
`include "mono_last_note_priority_stack_assert.svh"

module mlnps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mlnps_pkg::dp_status_t status,
  output mlnps_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [5:0] cmd_bits;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!status.scan_req) begin
          state_next = S_FINISH;
        end else if (status.scan_done) begin
          cmd.scan_end = 1'b1;
          state_next   = S_CHECK;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_CHECK: begin
        state_next = (status.note_on && status.full) ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (status.shift_done) begin
          cmd.shift_end = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_bits = cmd;

  `ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd_bits), "more than one datapath command")
  `ASSERT_NEXT(a_finish_wait, state == S_FINISH && status.out_busy, state == S_FINISH, "left finish while result pending")
  `ASSERT_NEXT(a_load_scan, cmd.load, state == S_SCAN, "load not followed by scan")

endmodule

// File: hw/rtl/mono_last_note_priority_stack.sv
// Steps: a note on/off is loaded, compacted over the n held notes and checked; a note on
// to a full stack then evicts the oldest entry by a shift pass; finish loads the result.
// Other requests go from load to finish. One event at a time; compaction scans one entry
// per cycle over the single read port. A pending result stalls the next event at finish.
// Reset: synchronous; empties the stack; internal voice gate low, note 33, velocity 0.
// Top level; instantiates mlnps_ctrl and mlnps_dp, uses mlnps_pkg.

module mono_last_note_priority_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mlnps_pkg::REQ_W-1:0]   req_type,
  input  logic [mlnps_pkg::NOTE_W-1:0]  note_number,
  input  logic [mlnps_pkg::VEL_W-1:0]   note_velocity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          gate_on,
  output logic [mlnps_pkg::NOTE_W-1:0]  target_note,
  output logic [mlnps_pkg::VEL_W-1:0]   target_velocity,
  output logic [mlnps_pkg::HELD_W-1:0]  held_count,
  output logic                          oldest_dropped
);

  mlnps_pkg::dp_cmd_t    cmd;
  mlnps_pkg::dp_status_t status;

  mlnps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mlnps_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req_type),
    .note_number     (note_number),
    .note_velocity   (note_velocity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .gate_on         (gate_on),
    .target_note     (target_note),
    .target_velocity (target_velocity),
    .held_count      (held_count),
    .oldest_dropped  (oldest_dropped)
  );

endmodule

// File: verif/mlnps_voice_checker.sv
// Checker for the mono last-note-priority note stack: tracks the held-note stack
// from accepted events and compares every result beat against its prediction.
// Depends on mlnps_pkg for widths, request codes, stack depth and the reset note.
`timescale 1ns / 100ps

module mlnps_voice_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [mlnps_pkg::REQ_W-1:0]   req_type,
  input  logic [mlnps_pkg::NOTE_W-1:0]  note_number,
  input  logic [mlnps_pkg::VEL_W-1:0]   note_velocity,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          gate_on,
  input  logic [mlnps_pkg::NOTE_W-1:0]  target_note,
  input  logic [mlnps_pkg::VEL_W-1:0]   target_velocity,
  input  logic [mlnps_pkg::HELD_W-1:0]  held_count,
  input  logic                          oldest_dropped,
  output int                            mismatches,
  output int                            voices_pending
);

  typedef struct packed {
    logic                         gate;
    logic [mlnps_pkg::NOTE_W-1:0] note;
    logic [mlnps_pkg::VEL_W-1:0]  vel;
    logic [mlnps_pkg::HELD_W-1:0] held;
    logic                         dropped;
  } voice_t;

  // predicted stack, oldest at index 0
  logic [mlnps_pkg::NOTE_W-1:0] held_notes [mlnps_pkg::STACK_DEPTH];
  logic [mlnps_pkg::VEL_W-1:0]  held_vels  [mlnps_pkg::STACK_DEPTH];
  int                           held_n;
  logic [mlnps_pkg::NOTE_W-1:0] cur_note;
  logic [mlnps_pkg::VEL_W-1:0]  cur_vel;
  logic                         gate_st;

  voice_t expected_voices [$];
  voice_t pred;
  voice_t want;
  voice_t got;

  // compaction: drop every copy of the note, order kept
  function automatic void drop_note(input logic [mlnps_pkg::NOTE_W-1:0] note);
    int wr;
    wr = 0;
    for (int rd = 0; rd < held_n; rd++) begin
      if (held_notes[rd] != note) begin
        held_notes[wr] = held_notes[rd];
        held_vels[wr]  = held_vels[rd];
        wr++;
      end
    end
    held_n = wr;
  endfunction

  function automatic voice_t next_voice(input logic [mlnps_pkg::REQ_W-1:0]  req,
                                        input logic [mlnps_pkg::NOTE_W-1:0] note,
                                        input logic [mlnps_pkg::VEL_W-1:0]  vel);
    voice_t r;
    r.dropped = 1'b0;
    case (req)
      mlnps_pkg::REQ_NOTE_ON: begin
        drop_note(note);
        if (held_n >= mlnps_pkg::STACK_DEPTH) begin
          for (int k = 0; k < mlnps_pkg::STACK_DEPTH - 1; k++) begin
            held_notes[k] = held_notes[k+1];
            held_vels[k]  = held_vels[k+1];
          end
          held_n    = mlnps_pkg::STACK_DEPTH - 1;
          r.dropped = 1'b1;
        end
        held_notes[held_n] = note;
        held_vels[held_n]  = vel;
        held_n++;
        cur_note = note;
        cur_vel  = vel;
        gate_st  = 1'b1;
      end
      mlnps_pkg::REQ_NOTE_OFF: begin
        drop_note(note);
        if (held_n == 0) begin
          gate_st = 1'b0;
        end else begin
          cur_note = held_notes[held_n-1];
          cur_vel  = held_vels[held_n-1];
          gate_st  = 1'b1;
        end
      end
      mlnps_pkg::REQ_ALL_OFF: begin
        held_n   = 0;
        cur_note = mlnps_pkg::RESET_NOTE;
        cur_vel  = '0;
        gate_st  = 1'b0;
      end
      default: ;  // unused code: state untouched
    endcase
    r.gate = gate_st;
    r.note = cur_note;
    r.vel  = cur_vel;
    r.held = mlnps_pkg::HELD_W'(held_n);
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_n   = 0;
      cur_note = mlnps_pkg::RESET_NOTE;
      cur_vel  = '0;
      gate_st  = 1'b0;
      expected_voices.delete();
    end else begin
      if (in_valid && in_ready) begin
        pred = next_voice(req_type, note_number, note_velocity);
        expected_voices = {expected_voices, pred};
      end
      if (out_valid && out_ready) begin
        got = '{gate_on, target_note, target_velocity, held_count, oldest_dropped};
        if (expected_voices.size() == 0) begin
          $error("result beat with no event outstanding: note %0d held %0d",
                 target_note, held_count);
          mismatches++;
        end else begin
          want = expected_voices.pop_front();
          check_field("gate_on", want.gate, got.gate);
          check_field("target_note", want.note, got.note);
          check_field("target_velocity", want.vel, got.vel);
          check_field("held_count", want.held, got.held);
          check_field("oldest_dropped", want.dropped, got.dropped);
        end
      end
    end
    voices_pending <= expected_voices.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for mono_last_note_priority_stack: clock, reset, event stimulus,
// randomized result back-pressure and the verdict. Checking is in mlnps_voice_checker.
// Depends on mlnps_pkg and the RTL of the note stack.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [mlnps_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int NUM_RANDOM  = 1800;
  localparam int POOL_SPAN   = 20;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 500;
  localparam int TAIL_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [mlnps_pkg::REQ_W-1:0]  req_type;
  logic [mlnps_pkg::NOTE_W-1:0] note_number;
  logic [mlnps_pkg::VEL_W-1:0]  note_velocity;
  logic                         out_valid;
  logic                         out_ready;
  logic                         gate_on;
  logic [mlnps_pkg::NOTE_W-1:0] target_note;
  logic [mlnps_pkg::VEL_W-1:0]  target_velocity;
  logic [mlnps_pkg::HELD_W-1:0] held_count;
  logic                         oldest_dropped;
  int                           mismatches;
  int                           voices_pending;

  logic send_burst;   // no gaps between events while set
  int   taken;

  always #5 clk = ~clk;

  mono_last_note_priority_stack u_dut (
    .clk, .rst,
    .in_valid, .in_ready, .req_type, .note_number, .note_velocity,
    .out_valid, .out_ready, .gate_on, .target_note, .target_velocity,
    .held_count, .oldest_dropped
  );

  mlnps_voice_checker u_checker (
    .clk, .rst,
    .in_valid, .in_ready, .req_type, .note_number, .note_velocity,
    .out_valid, .out_ready, .gate_on, .target_note, .target_velocity,
    .held_count, .oldest_dropped,
    .mismatches, .voices_pending
  );

  task automatic send_event(input logic [mlnps_pkg::REQ_W-1:0]  req,
                            input logic [mlnps_pkg::NOTE_W-1:0] note,
                            input logic [mlnps_pkg::VEL_W-1:0]  vel);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    note_number   <= note;
    note_velocity <= vel;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (voices_pending != 0);
  endtask

  // receiver: random stalls per beat, gapless stretches, one long hold-off
  initial begin
    int gap;
    out_ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT)
        gap = LONG_HOLD;
      else if ((taken / 120) % 3 == 2)
        gap = 0;
      else
        gap = $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    int                           sel;
    logic [mlnps_pkg::NOTE_W-1:0] pool_base;
    logic [mlnps_pkg::NOTE_W-1:0] nt;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    req_type      <= mlnps_pkg::REQ_NOTE_ON;
    note_number   <= '0;
    note_velocity <= '0;
    send_burst    = 1'b0;
    pool_base     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-stack release, unused code, panic, dup, unheld release
    send_event(mlnps_pkg::REQ_NOTE_OFF, 7'd5, 7'd99);
    send_event(REQ_UNUSED, 7'd127, 7'd127);
    send_event(mlnps_pkg::REQ_ALL_OFF, 7'd64, 7'd64);
    send_event(mlnps_pkg::REQ_NOTE_ON, 7'd127, 7'd127);
    send_event(mlnps_pkg::REQ_NOTE_ON, 7'd127, 7'd5);
    send_event(mlnps_pkg::REQ_NOTE_OFF, 7'd64, 7'd0);
    send_event(mlnps_pkg::REQ_NOTE_OFF, 7'd127, 7'd0);   // empties stack, target kept
    // fill to depth, then one more evicts the oldest
    for (int k = 0; k < mlnps_pkg::STACK_DEPTH; k++)
      send_event(mlnps_pkg::REQ_NOTE_ON, mlnps_pkg::NOTE_W'(k * 8),
                 mlnps_pkg::VEL_W'(127 - k * 8));
    send_event(mlnps_pkg::REQ_NOTE_ON, 7'd127, 7'd0);
    send_event(mlnps_pkg::REQ_ALL_OFF, 7'd0, 7'd0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_burst = ((i / 150) % 4 == 3);
      if (i % 200 == 0)
        pool_base = mlnps_pkg::NOTE_W'($urandom_range(0, 127 - POOL_SPAN));
      if (i == NUM_RANDOM / 2)
        wait_drained();
      sel = $urandom_range(0, 99);
      // mostly notes from a narrow pool so releases hit held notes
      if ($urandom_range(0, 9) == 0)
        nt = mlnps_pkg::NOTE_W'($urandom_range(0, 127));
      else
        nt = pool_base + mlnps_pkg::NOTE_W'($urandom_range(0, POOL_SPAN - 1));
      if (i % 300 < 20 || (sel >= 5 && sel < 60))
        send_event(mlnps_pkg::REQ_NOTE_ON, nt, mlnps_pkg::VEL_W'($urandom_range(0, 127)));
      else if (sel < 3)
        send_event(mlnps_pkg::REQ_ALL_OFF, nt, mlnps_pkg::VEL_W'($urandom_range(0, 127)));
      else if (sel < 5)
        send_event(REQ_UNUSED, nt, mlnps_pkg::VEL_W'($urandom_range(0, 127)));
      else
        send_event(mlnps_pkg::REQ_NOTE_OFF, nt, mlnps_pkg::VEL_W'($urandom_range(0, 127)));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && voices_pending == 0)
      $display("mono_last_note_priority_stack regression: pass");
    else
      $display("mono_last_note_priority_stack regression: fail");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("mono_last_note_priority_stack regression: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mlnps_pkg.sv
hw/rtl/mlnps_dp.sv
hw/rtl/mlnps_ctrl.sv
hw/rtl/mono_last_note_priority_stack.sv
verif/mlnps_voice_checker.sv
verif/tb_top.sv
